// ===== rtl/core/s2i_pkg.sv =====
// Shared widths, character codes, register indexes and digit decoding for the parser.
package s2i_pkg;

  localparam int CHAR_W    = 8;
  localparam int VAL_W     = 64;
  localparam int CNT_W     = 16;
  localparam int RADIX_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = 16'd65535;

  localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_BAD  = 6'd1;
  localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [RADIX_W-1:0] NOT_DIGIT  = 6'd63;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'b1;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_dec(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Letters fold to upper case: A and a both give ten
  function automatic logic [RADIX_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = CH_ZERO;
    if (is_dec(c)) begin
      d = c - CH_ZERO;
    end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
      d = c - CH_UPPER_A + 8'd10;
    end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) begin
      d = c - CH_LOWER_A + 8'd10;
    end else begin
      d = {2'b00, NOT_DIGIT};
    end
    return d[RADIX_W-1:0];
  endfunction

endpackage

// ===== rtl/core/s2i_ifs.sv =====
// Character and result channel interfaces for the parser.
interface s2i_in_if;
  import s2i_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              start_string;
  modport source (output valid, output ch, output start_string, input ready);
  modport sink   (input valid, input ch, input start_string, output ready);
endinterface

interface s2i_out_if;
  import s2i_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value_bits;
  logic [CNT_W-1:0] consumed;
  modport source (output valid, output value_bits, output consumed, input ready);
  modport sink   (input valid, input value_bits, input consumed, output ready);
endinterface

// ===== rtl/core/string_to_integer_parser.sv =====
// Streaming string-to-integer parser: one character word in, at most one result word out.
//
// in_bus carries one character per word with start_string marking the first character
// of a string. out_bus carries the parsed value (two's complement after a minus sign)
// and the number of characters consumed, saturating at COUNT_MAX. At most one result word is
// produced for each string, at the first character that is not part of the number, or
// at once on the start character when the latched radix is 1 or above 36.
// cfg_we/cfg_index/cfg_wdata write radix (index 0) and signed_mode (index 1); write
// only while the block is idle. The radix is sampled at each string start.
//
// The word that ends the number is first held in the input register; the state update
// and the result register then load together when that word advances.
// Throughput: one character per cycle while out_bus is not stalled; each cycle's path is a
// digit decode and one 64 by 6 bit multiply-add on the accumulator.
// The input register keeps taking words while a result waits; when out_bus stalls with
// both registers full, in_bus.ready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, restores radix 10 and signed
// mode, and leaves the parser waiting for a new string.
module string_to_integer_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  s2i_in_if.sink                          in_bus,
  s2i_out_if.source                       out_bus,
  input  logic                            cfg_we,
  input  logic [s2i_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [s2i_pkg::RADIX_W-1:0]     cfg_wdata
);
  import s2i_pkg::*;

  typedef enum logic [2:0] {
    PH_DONE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  // configuration
  logic [RADIX_W-1:0] radix_r;
  logic               signed_mode_r;

  // input register
  logic               s1_valid_r;
  logic [CHAR_W-1:0]  s1_ch_r;
  logic               s1_start_r;

  // parse state
  phase_t             phase_r, phase_nxt;
  logic [VAL_W-1:0]   acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  logic [RADIX_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // result register
  logic               out_valid_r;
  logic [VAL_W-1:0]   out_value_r, out_value_nxt;
  logic [CNT_W-1:0]   out_cons_r, out_cons_nxt;

  logic               adv;
  logic               emit;

  assign adv          = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || adv;

  assign out_bus.valid      = out_valid_r;
  assign out_bus.value_bits = out_value_r;
  assign out_bus.consumed   = out_cons_r;

  always_comb begin
    logic               num_start;
    logic               take;
    logic               bump;
    logic               b_auto;
    logic [RADIX_W-1:0] dv;

    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    emit          = 1'b0;
    num_start     = 1'b0;
    take          = 1'b0;
    bump          = 1'b0;
    out_value_nxt = out_value_r;
    out_cons_nxt  = out_cons_r;

    if (s1_start_r) begin
      acc_nxt  = '0;
      neg_nxt  = 1'b0;
      cnt_nxt  = '0;
      base_nxt = radix_r;
      if ((radix_r == RADIX_BAD) || (radix_r > RADIX_MAX)) begin
        phase_nxt = PH_DONE;
        emit      = 1'b1;
      end else begin
        phase_nxt = PH_LEAD;
      end
    end

    b_auto = (base_nxt == RADIX_AUTO);

    if (!emit) begin
      unique case (phase_nxt)
        PH_LEAD: begin
          if (is_space(s1_ch_r)) begin
            bump = 1'b1;
          end else if (signed_mode_r && ((s1_ch_r == CH_PLUS) || (s1_ch_r == CH_MINUS))) begin
            neg_nxt   = (s1_ch_r == CH_MINUS);
            bump      = 1'b1;
            phase_nxt = PH_SIGNED;
          end else begin
            num_start = 1'b1;
          end
        end
        PH_SIGNED: begin
          num_start = 1'b1;
        end
        PH_ZERO: begin
          if ((b_auto || (base_nxt == RADIX_HEX)) && ((s1_ch_r | CASE_BIT) == CH_LOWER_X)) begin
            base_nxt  = RADIX_HEX;
            bump      = 1'b1;
            phase_nxt = PH_DIGITS;
          end else begin
            if ((b_auto || (base_nxt == RADIX_OCT)) && is_dec(s1_ch_r)) begin
              base_nxt = RADIX_OCT;
            end else if (b_auto) begin
              base_nxt = RADIX_DEC;
            end
            phase_nxt = PH_DIGITS;
            take      = 1'b1;
          end
        end
        PH_DIGITS: begin
          take = 1'b1;
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      if (num_start) begin
        if ((s1_ch_r == CH_ZERO) &&
            (b_auto || (base_nxt == RADIX_OCT) || (base_nxt == RADIX_HEX))) begin
          bump      = 1'b1;
          phase_nxt = PH_ZERO;
        end else begin
          if (b_auto) begin
            base_nxt = RADIX_DEC;
          end
          phase_nxt = PH_DIGITS;
          take      = 1'b1;
        end
      end
    end

    dv = digit_value(s1_ch_r);
    if (take) begin
      if (dv < base_nxt) begin
        acc_nxt = acc_nxt * {{(VAL_W-RADIX_W){1'b0}}, base_nxt} +
                  {{(VAL_W-RADIX_W){1'b0}}, dv};
        bump    = 1'b1;
      end else begin
        emit      = 1'b1;
        phase_nxt = PH_DONE;
      end
    end

    if (bump && (cnt_nxt < COUNT_MAX)) begin
      cnt_nxt = cnt_nxt + CNT_W'(1);
    end

    if (emit) begin
      out_value_nxt = neg_nxt ? (VAL_W'(0) - acc_nxt) : acc_nxt;
      out_cons_nxt  = cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r       <= RADIX_DEC;
      signed_mode_r <= 1'b1;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_r       <= PH_DONE;
      acc_r         <= '0;
      neg_r         <= 1'b0;
      base_r        <= RADIX_DEC;
      cnt_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RADIX:       radix_r       <= cfg_wdata;
          REG_SIGNED_MODE: signed_mode_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end

      if (in_bus.valid && in_bus.ready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end

      if (adv) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        cnt_r   <= cnt_nxt;
      end

      // drop a taken result; load a new one when the word advances
      if (!out_valid_r || out_bus.ready) begin
        out_valid_r <= adv && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_ch_r    <= in_bus.ch;
      s1_start_r <= in_bus.start_string;
    end
    if (adv && emit) begin
      out_value_r <= out_value_nxt;
      out_cons_r  <= out_cons_nxt;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_bus.ready) |=> s1_valid_r)
    else $error("buffered word lost while the result was stalled");

  a_ready_low_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (s1_valid_r && out_valid_r && !out_bus.ready))
    else $error("input held off with room to advance");

  a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && emit))
    else $error("result raised without an advancing word");

  a_emit_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit) |=> (phase_r == PH_DONE))
    else $error("parse still open after a result");

endmodule

// ===== tb/string_to_integer_parser_tb.sv =====
// Self-checking testbench for the streaming string-to-integer parser.
module string_to_integer_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import s2i_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          IDLE_PCT    = 27;
  localparam int          SETTLE_GAP  = 8;
  localparam int unsigned NO_DIGIT    = 99;
  localparam int          RUN_LEN     = 160;

  typedef enum logic [2:0] {
    PS_DONE, PS_LEAD, PS_SIGNED, PS_ZERO, PS_DIGITS
  } parse_phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              start;
  } char_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] value_bits;
    logic [CNT_W-1:0] consumed;
  } parse_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RADIX_W-1:0]   cfg_wdata;

  s2i_in_if  in_bus ();
  s2i_out_if out_bus ();

  string_to_integer_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  char_word_t    char_backlog[$];
  parse_result_t pending_results[$];

  // Shadow registers and parser state
  logic [RADIX_W-1:0] cfg_radix;
  logic               cfg_signed;
  parse_phase_t       ph   = PS_DONE;
  logic [VAL_W-1:0]   acc  = '0;
  logic               neg  = 1'b0;
  logic [RADIX_W-1:0] base = RADIX_DEC;
  logic [CNT_W-1:0]   cnt  = '0;

  bit steady;
  int n_errors    = 0;
  int n_chars     = 0;
  int n_results   = 0;
  int n_queued;
  int n_settings;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int unsigned char_digit(input logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return {24'd0, c - CH_ZERO};
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return {24'd0, c - CH_UPPER_A + 8'd10};
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return {24'd0, c - CH_LOWER_A + 8'd10};
    return NO_DIGIT;
  endfunction

  function automatic void count_up();
    if (cnt != COUNT_MAX) cnt = cnt + CNT_W'(1);
  endfunction

  // Advance the parser by one character; returns 1 when a result word is due.
  function automatic bit parse_char(input logic [CHAR_W-1:0] c, input logic first,
                                    output parse_result_t res);
    logic [RADIX_W-1:0] b;
    int unsigned        d;
    res = '0;
    if (first) begin
      acc  = '0;
      neg  = 1'b0;
      cnt  = '0;
      base = cfg_radix;
      if (base == RADIX_BAD || base > RADIX_MAX) begin
        ph = PS_DONE;
        return 1'b1;
      end
      ph = PS_LEAD;
    end
    b = base;
    if (ph == PS_DONE) return 1'b0;
    if (ph == PS_LEAD) begin
      if (is_blank(c)) begin
        count_up();
        return 1'b0;
      end
      if (cfg_signed && (c == CH_PLUS || c == CH_MINUS)) begin
        neg = (c == CH_MINUS);
        count_up();
        ph = PS_SIGNED;
        return 1'b0;
      end
      ph = PS_SIGNED;
    end
    if (ph == PS_SIGNED) begin
      if (c == CH_ZERO && (b == RADIX_AUTO || b == RADIX_OCT || b == RADIX_HEX)) begin
        count_up();
        ph = PS_ZERO;
        return 1'b0;
      end
      if (b == RADIX_AUTO) base = RADIX_DEC;
      ph = PS_DIGITS;
    end else if (ph == PS_ZERO) begin
      if ((b == RADIX_AUTO || b == RADIX_HEX) && (c | CASE_BIT) == CH_LOWER_X) begin
        base = RADIX_HEX;
        count_up();
        ph = PS_DIGITS;
        return 1'b0;
      end
      if ((b == RADIX_AUTO || b == RADIX_OCT) && c >= CH_ZERO && c <= CH_NINE) begin
        base = RADIX_OCT;
      end else if (b == RADIX_AUTO) begin
        base = RADIX_DEC;
      end
      ph = PS_DIGITS;
    end
    d = char_digit(c);
    if (d < base) begin
      acc = acc * 64'(base) + 64'(d);
      count_up();
      return 1'b0;
    end
    res.value_bits = neg ? (64'd0 - acc) : acc;
    res.consumed   = cnt;
    ph = PS_DONE;
    return 1'b1;
  endfunction

  // Character driver: hold a word until taken, idle at random between words
  always @(posedge clk) begin
    parse_result_t r;
    char_word_t    w;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        n_chars++;
        if (parse_char(in_bus.ch, in_bus.start_string, r)) pending_results.push_back(r);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (char_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          w = char_backlog.pop_front();
          in_bus.valid        <= 1'b1;
          in_bus.ch           <= w.ch;
          in_bus.start_string <= w.start;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    parse_result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          n_errors++;
          $error("unexpected result word: value_bits %h consumed %0d",
                 out_bus.value_bits, out_bus.consumed);
        end else begin
          want = pending_results.pop_front();
          if (out_bus.value_bits !== want.value_bits) begin
            n_errors++;
            $error("value_bits mismatch: expected %h, actual %h",
                   want.value_bits, out_bus.value_bits);
          end
          if (out_bus.consumed !== want.consumed) begin
            n_errors++;
            $error("consumed mismatch: expected %0d, actual %0d",
                   want.consumed, out_bus.consumed);
          end
        end
      end
      out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_char(input logic [CHAR_W-1:0] c, input logic s);
    char_backlog.push_back('{ch: c, start: s});
    n_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RADIX_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_RADIX) cfg_radix = data;
    else cfg_signed = data[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [RADIX_W-1:0] r, input logic s);
    write_reg(REG_RADIX, r);
    write_reg(REG_SIGNED_MODE, {{(RADIX_W-1){1'b0}}, s});
    n_settings++;
  endtask

  // Hold the sender until every expected word is back and the pipeline is empty
  task automatic settle();
    while (char_backlog.size() != 0 || in_bus.valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] rand_blank();
    int unsigned k;
    k = $urandom_range(5);
    return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v - 10);
  endfunction

  // One string: blanks, optional sign, optional prefix, digits, then a random stop byte and sometimes more random bytes
  task automatic gen_string();
    int unsigned ndig, eff, k, r;
    bit          hex_pfx, oct_pfx, first;
    first   = 1'b1;
    hex_pfx = 1'b0;
    oct_pfx = 1'b0;
    r = cfg_radix;
    k = $urandom_range(3);
    repeat (k) begin
      add_char(rand_blank(), first);
      first = 1'b0;
    end
    if ($urandom_range(99) < 45) begin
      add_char($urandom_range(1) ? CH_MINUS : CH_PLUS, first);
      first = 1'b0;
      if ($urandom_range(99) < 8) add_char(rand_blank(), 1'b0);
    end
    if ((r == RADIX_AUTO || r == RADIX_HEX) && $urandom_range(99) < 35) begin
      add_char(CH_ZERO, first);
      add_char($urandom_range(1) ? CH_LOWER_X : (CH_LOWER_X & ~CASE_BIT), 1'b0);
      first   = 1'b0;
      hex_pfx = 1'b1;
    end else if ((r == RADIX_AUTO || r == RADIX_OCT) && $urandom_range(99) < 30) begin
      add_char(CH_ZERO, first);
      first   = 1'b0;
      oct_pfx = 1'b1;
    end
    if (hex_pfx) eff = RADIX_HEX;
    else if (r == RADIX_AUTO) eff = oct_pfx ? RADIX_OCT : RADIX_DEC;
    else if (r < 2 || r > RADIX_MAX) eff = RADIX_DEC;
    else eff = r;
    ndig = ($urandom_range(99) < 15) ? $urandom_range(14, 70) : $urandom_range(0, 6);
    repeat (ndig) begin
      add_char(digit_char($urandom_range(eff - 1)), first);
      first = 1'b0;
    end
    add_char(8'($urandom_range(255)), first);
    if ($urandom_range(99) < 30) begin
      k = $urandom_range(1, 3);
      repeat (k) add_char(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic gen_noise();
    int unsigned k;
    k = $urandom_range(1, 8);
    repeat (k) add_char(8'($urandom_range(255)), $urandom_range(99) < 20);
  endtask

  task automatic random_phase(input logic [RADIX_W-1:0] r, input logic s, input int target);
    int stop_at;
    set_config(r, s);
    stop_at = n_queued + target;
    while (n_queued < stop_at) begin
      if ($urandom_range(99) < 12) gen_noise();
      else gen_string();
    end
    settle();
  endtask

  initial begin
    int unsigned rr;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    steady              = 1'b0;
    n_queued = 0; n_settings = 1;
    cfg_radix  = RADIX_DEC;
    cfg_signed = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: decimal, signed
    add_char(CH_SPACE, 1'b1); add_char(CH_MINUS, 1'b0);
    add_char("1", 1'b0); add_char("2", 1'b0); add_char("x", 1'b0);
    add_char(CH_PLUS, 1'b1); add_char("z", 1'b0);
    add_char(8'hFF, 1'b1); add_char("5", 1'b0);
    // drop an unfinished parse at a new start
    add_char("4", 1'b1); add_char("2", 1'b0);
    add_char("7", 1'b1); add_char(":", 1'b0);
    add_char(CH_MINUS, 1'b1); add_char(CH_SPACE, 1'b0);
    settle();

    // Base detection, unsigned: bare prefix, octal cut short by 8, refused sign
    set_config(RADIX_AUTO, 1'b0);
    add_char(CH_ZERO, 1'b1); add_char(CH_LOWER_X, 1'b0); add_char("g", 1'b0);
    add_char(CH_ZERO, 1'b1); add_char("8", 1'b0);
    add_char(CH_MINUS, 1'b1);
    add_char(8'h00, 1'b1);
    settle();

    // Bad radix answers on the start byte and ignores the rest
    set_config(RADIX_BAD, 1'b1);
    add_char(CH_UPPER_A, 1'b1); add_char("B", 1'b0);
    settle();

    random_phase(RADIX_AUTO, 1'b1, 130);
    random_phase(RADIX_AUTO, 1'b0, 130);
    random_phase(6'd2, 1'b1, 130);
    random_phase(RADIX_OCT, 1'b0, 130);
    random_phase(RADIX_DEC, 1'b1, 130);
    random_phase(RADIX_HEX, 1'b0, 130);
    random_phase(RADIX_HEX, 1'b1, 130);
    random_phase(RADIX_MAX, 1'b1, 130);
    random_phase(RADIX_MAX, 1'b0, 130);
    random_phase(6'd37, 1'b1, 30);
    random_phase(6'd63, 1'b0, 30);
    repeat (4) begin
      rr = $urandom_range(1) ? $urandom_range(2, 36) : $urandom_range(0, 63);
      random_phase(RADIX_W'(rr), 1'($urandom_range(1)), 100);
    end

    // Run one long string at full rate with no idling on either side
    set_config(RADIX_DEC, 1'b1);
    steady = 1'b1;
    add_char(CH_SPACE, 1'b1);
    for (int i = 1; i < RUN_LEN; i++)
      add_char((i < RUN_LEN / 4) ? CH_SPACE : CH_ZERO + 8'(i % 10), 1'b0);
    add_char(";", 1'b0);
    settle();
    steady = 1'b0;

    $display("Sent %0d characters under %0d register settings, checked %0d result words.",
             n_chars, n_settings, n_results);
    $display("Covered prefixes, octal, bad radices, signs, wrap-around and a full-rate run.");
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
